// ===== src/fpg_pkg.sv =====
// Shared types, constants and lookup functions for the fuzz payload generator.
package fpg_pkg;

  localparam int PAYLOAD_MAX_DEF = 20;
  localparam int TABLE_LEN       = 22;
  localparam int FMT_LEN         = 10;

  localparam logic [31:0] SEED_BASE     = 32'h1234_ABCD;
  localparam logic [31:0] SEED_MUL      = 32'h9E37_79B1;
  localparam logic [31:0] SEED_ZERO_FIX = 32'hDEAD_BEEF;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BUILD = 1'b1;

  // fixed corpus iteration numbers
  localparam logic [15:0] ITER_EMPTY    = 16'd0;
  localparam logic [15:0] ITER_ONE_00   = 16'd1;
  localparam logic [15:0] ITER_ONE_FF   = 16'd2;
  localparam logic [15:0] ITER_ONE_7F   = 16'd3;
  localparam logic [15:0] ITER_ONE_80   = 16'd4;
  localparam logic [15:0] ITER_FILL_00  = 16'd5;
  localparam logic [15:0] ITER_FILL_FF  = 16'd6;
  localparam logic [15:0] ITER_FILL_41  = 16'd7;
  localparam logic [15:0] ITER_RAMP     = 16'd8;
  localparam logic [15:0] ITER_FMT      = 16'd9;
  localparam logic [15:0] ITER_ALT      = 16'd10;

  // length draw codes (low three bits of the first step)
  localparam logic [2:0] LCODE_ONE   = 3'd0;
  localparam logic [2:0] LCODE_MAX_A = 3'd1;
  localparam logic [2:0] LCODE_MAX_B = 3'd2;

  // byte draw codes (low two bits of the byte step)
  localparam logic [1:0] KIND_TAB_A = 2'd0;
  localparam logic [1:0] KIND_TAB_B = 2'd1;
  localparam logic [1:0] KIND_HIGH  = 2'd2;
  localparam logic [1:0] KIND_POS   = 2'd3;

  typedef enum logic {
    MSRC_LEN  = 1'b0,
    MSRC_BYTE = 1'b1
  } msrc_t;

  // controller -> datapath
  typedef struct packed {
    logic  take;
    logic  seed_load;
    logic  prng_step;
    logic  len_corpus;
    logic  len_from_r;
    logic  len_from_mod;
    logic  mod_start;
    msrc_t mod_sel;
    logic  mod_step;
    logic  idx_clear;
    logic  idx_inc;
    logic  emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_corpus;
    logic r_short;
    logic mod_done;
    logic last_byte;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'h00;
      5'd1:    b = 8'h01;
      5'd2:    b = 8'h02;
      5'd3:    b = 8'h03;
      5'd4:    b = 8'h04;
      5'd5:    b = 8'h07;
      5'd6:    b = 8'h08;
      5'd7:    b = 8'h0A;
      5'd8:    b = 8'h0D;
      5'd9:    b = 8'h10;
      5'd10:   b = 8'h20;
      5'd11:   b = 8'h25;
      5'd12:   b = 8'h2F;
      5'd13:   b = 8'h40;
      5'd14:   b = 8'h41;
      5'd15:   b = 8'h5C;
      5'd16:   b = 8'h7E;
      5'd17:   b = 8'h7F;
      5'd18:   b = 8'h80;
      5'd19:   b = 8'h81;
      5'd20:   b = 8'hFE;
      5'd21:   b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "%s%n%x%p%d"
  function automatic logic [7:0] fmt_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd1:    b = 8'h73;
      4'd3:    b = 8'h6E;
      4'd5:    b = 8'h78;
      4'd7:    b = 8'h70;
      4'd9:    b = 8'h64;
      default: b = 8'h25;
    endcase
    return b;
  endfunction

endpackage

// ===== src/fpg_mod.sv =====
// Iterative remainder unit: 32-bit dividend, eight bits per cycle.
module fpg_mod #(
  parameter int RW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          step,
  input  logic [31:0]   src,
  input  logic [RW-1:0] modulus,
  output logic [RW-1:0] rem,
  output logic          done
);

  logic [31:0]   shreg;
  logic [2:0]    cnt;
  logic [RW-1:0] rem_next;

  // restoring reduction, one dividend bit per inner step
  always_comb begin
    logic [RW:0] t;
    rem_next = rem;
    for (int k = 0; k < 8; k++) begin
      t = {rem_next, shreg[31-k]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_next = t[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd4;
    end else if (start) begin
      cnt <= 3'd0;
    end else if (step && !cnt[2]) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= src;
      rem   <= '0;
    end else if (step && !cnt[2]) begin
      shreg <= shreg << 8;
      rem   <= rem_next;
    end
  end

  assign done = cnt[2];

endmodule

// ===== src/fpg_dp.sv =====
// Datapath: seed, PRNG, length and byte selection, output register.
module fpg_dp #(
  parameter int PAYLOAD_MAX = fpg_pkg::PAYLOAD_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          req_type,
  input  logic [15:0]   iteration,
  input  fpg_pkg::cmd_t cmd,
  output fpg_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    payload_byte,
  output logic [4:0]    byte_index,
  output logic [4:0]    payload_length,
  output logic          is_empty,
  output logic          last
);

  localparam int LW0    = $clog2(PAYLOAD_MAX + 1);
  localparam int LW     = (LW0 > 5) ? LW0 : 5;
  localparam int MODMAX = (PAYLOAD_MAX > fpg_pkg::TABLE_LEN) ? PAYLOAD_MAX
                                                             : fpg_pkg::TABLE_LEN;
  localparam int RW     = $clog2(MODMAX) + 1;

  logic [15:0]   target_handle;
  logic [31:0]   prng_state;
  logic [31:0]   seed_prod;
  logic          req_start;
  logic [15:0]   iter;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [31:0]   rand_v;

  logic [31:0]   prng_nxt;
  logic [31:0]   seed_raw;
  logic [31:0]   mod_src;
  logic [RW-1:0] modulus;
  logic [RW-1:0] mod_rem;
  logic          mod_done;
  logic          is_corpus;
  logic [LW-1:0] corpus_len;
  logic [7:0]    corpus_b;
  logic [7:0]    rand_b;
  logic [7:0]    byte_sel;
  logic [LW-1:0] idx_plus;
  logic          r_short;

  assign prng_nxt = fpg_pkg::xorshift32(prng_state);
  assign seed_raw = fpg_pkg::SEED_BASE ^ seed_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_handle <= 16'd1;
    end else if (cfg_we) begin
      target_handle <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    seed_prod <= fpg_pkg::SEED_MUL * {16'd0, target_handle};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prng_state <= fpg_pkg::SEED_BASE;
    end else if (cmd.seed_load) begin
      if (target_handle != 16'd0) begin
        prng_state <= (seed_raw == 32'd0) ? fpg_pkg::SEED_ZERO_FIX : seed_raw;
      end
    end else if (cmd.prng_step) begin
      prng_state <= prng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_start <= (req_type == fpg_pkg::REQ_START);
      iter      <= iteration;
    end
    if (cmd.prng_step) begin
      rand_v <= prng_nxt;
    end
  end

  // remainder unit operands
  assign mod_src = (cmd.mod_sel == fpg_pkg::MSRC_BYTE) ? {2'b00, prng_nxt[31:2]} : prng_nxt;
  assign modulus = (cmd.mod_sel == fpg_pkg::MSRC_BYTE) ? RW'(fpg_pkg::TABLE_LEN)
                                                      : RW'(PAYLOAD_MAX);

  fpg_mod #(.RW(RW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mod_start),
    .step    (cmd.mod_step),
    .src     (mod_src),
    .modulus (modulus),
    .rem     (mod_rem),
    .done    (mod_done)
  );

  assign is_corpus = (iter <= fpg_pkg::ITER_ALT);

  always_comb begin
    case (iter)
      fpg_pkg::ITER_EMPTY: corpus_len = '0;
      fpg_pkg::ITER_ONE_00,
      fpg_pkg::ITER_ONE_FF,
      fpg_pkg::ITER_ONE_7F,
      fpg_pkg::ITER_ONE_80: corpus_len = LW'(1);
      fpg_pkg::ITER_FMT:    corpus_len = LW'(fpg_pkg::FMT_LEN);
      default:              corpus_len = LW'(PAYLOAD_MAX);
    endcase
  end

  always_comb begin
    case (iter)
      fpg_pkg::ITER_ONE_FF,
      fpg_pkg::ITER_FILL_FF: corpus_b = 8'hFF;
      fpg_pkg::ITER_ONE_7F:  corpus_b = 8'h7F;
      fpg_pkg::ITER_ONE_80:  corpus_b = 8'h80;
      fpg_pkg::ITER_FILL_41: corpus_b = 8'h41;
      fpg_pkg::ITER_RAMP:    corpus_b = 8'(idx);
      fpg_pkg::ITER_FMT:     corpus_b = fpg_pkg::fmt_byte(idx[3:0]);
      fpg_pkg::ITER_ALT:     corpus_b = idx[0] ? 8'h55 : 8'hAA;
      default:               corpus_b = 8'h00;
    endcase
  end

  always_comb begin
    case (rand_v[1:0])
      fpg_pkg::KIND_TAB_A,
      fpg_pkg::KIND_TAB_B: rand_b = fpg_pkg::pick_byte(mod_rem[4:0]);
      fpg_pkg::KIND_HIGH:  rand_b = rand_v[15:8];
      default:             rand_b = 8'(idx);
    endcase
  end

  assign byte_sel = is_corpus ? corpus_b : rand_b;

  always_comb begin
    case (prng_state[2:0])
      fpg_pkg::LCODE_ONE,
      fpg_pkg::LCODE_MAX_A,
      fpg_pkg::LCODE_MAX_B: r_short = 1'b1;
      default:              r_short = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.len_corpus) begin
      len <= corpus_len;
    end else if (cmd.len_from_r) begin
      len <= (prng_state[2:0] == fpg_pkg::LCODE_ONE) ? LW'(1) : LW'(PAYLOAD_MAX);
    end else if (cmd.len_from_mod) begin
      len <= LW'(mod_rem) + LW'(1);
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus;
    end
  end

  assign idx_plus = idx + LW'(1);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      payload_byte   <= (len == '0) ? 8'h00 : byte_sel;
      byte_index     <= idx[4:0];
      payload_length <= len[4:0];
      is_empty       <= (len == '0);
      last           <= (len == '0) || (idx_plus == len);
    end
  end

  assign sts.is_start  = req_start;
  assign sts.is_corpus = is_corpus;
  assign sts.r_short   = r_short;
  assign sts.mod_done  = mod_done;
  assign sts.last_byte = (len == '0) || (idx_plus == len);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== src/fpg_ctrl.sv =====
// Controller: sequences seeding, length draw and per-byte generation.
module fpg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fpg_pkg::sts_t sts,
  output fpg_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_SEED     = 8'b0000_0100,
    S_LEN      = 8'b0000_1000,
    S_LMOD     = 8'b0001_0000,
    S_BSTEP    = 8'b0010_0000,
    S_BMOD     = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_start) begin
          state_next = S_SEED;
        end else if (sts.is_corpus) begin
          cmd.len_corpus = 1'b1;
          cmd.idx_clear  = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.prng_step = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_LEN;
        end
      end
      S_SEED: begin
        cmd.seed_load = 1'b1;
        state_next    = S_IDLE;
      end
      S_LEN: begin
        if (sts.r_short) begin
          cmd.len_from_r = 1'b1;
          state_next     = S_BSTEP;
        end else begin
          cmd.prng_step = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = fpg_pkg::MSRC_LEN;
          state_next    = S_LMOD;
        end
      end
      S_LMOD: begin
        cmd.mod_sel = fpg_pkg::MSRC_LEN;
        if (sts.mod_done) begin
          cmd.len_from_mod = 1'b1;
          state_next       = S_BSTEP;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_BSTEP: begin
        cmd.prng_step = 1'b1;
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = fpg_pkg::MSRC_BYTE;
        state_next    = S_BMOD;
      end
      S_BMOD: begin
        cmd.mod_sel = fpg_pkg::MSRC_BYTE;
        if (sts.mod_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_byte) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = sts.is_corpus ? S_EMIT : S_BSTEP;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/fuzz_payload_generator_core.sv =====
// Top level of the fuzz payload generator: controller, datapath, ports.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  in       | in_valid / in_ready   | req_type, iteration
//  out      | out_valid / out_ready | payload_byte, byte_index, payload_length,
//           |                       | is_empty, last
//  cfg      | cfg_we (no wait)      | cfg_wdata -> target_handle
//
// Start item: accept, 32x16 seed multiply registered, seed write; no result.
// Corpus item (iterations 0..10): accept and dispatch, then one result per cycle
// while the out channel is free. Random item: the same accept and dispatch (first
// PRNG step taken in dispatch), then the length draw, or the modulo by PAYLOAD_MAX
// on the shared remainder unit (8 bits per cycle), then per byte: one PRNG step,
// the table pick in the remainder unit, and loading the result.
// Reset: synchronous; PRNG state returns to 0x1234ABCD, target_handle to 1.
// A stalled out channel holds the controller in its emit state; the next input item
// is taken once the last result of the current one sits in the output register.
module fuzz_payload_generator_core #(
  parameter int PAYLOAD_MAX = fpg_pkg::PAYLOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] iteration,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic [4:0]  byte_index,
  output logic [4:0]  payload_length,
  output logic        is_empty,
  output logic        last
);

  fpg_pkg::cmd_t cmd;
  fpg_pkg::sts_t sts;

  fpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpg_dp #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_type       (req_type),
    .iteration      (iteration),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .is_empty       (is_empty),
    .last           (last)
  );

endmodule
